@@ sv/blbf_pkg.sv @@
// Shared types, constants and color tables for the battery light bar fader.
// No dependencies; imported by every module of the block.
package blbf_pkg;

    localparam int PIXEL_COUNT = 4;
    localparam int CHAN_COUNT  = 3;
    localparam int CHAN_W      = 8;
    localparam int COLOR_W     = CHAN_COUNT * CHAN_W;
    localparam int FADE_W      = 16;
    localparam int PCT_W       = 8;
    localparam int PROD_W      = CHAN_W + FADE_W;
    localparam int STEP_W      = $clog2(CHAN_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CHAN_W - 1);

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_BAR_ENABLED = 1'b0;
    localparam logic REG_FADE_STEPS  = 1'b1;
    localparam logic [FADE_W-1:0] FADE_STEPS_RST = 16'd1000;

    // Item command codes
    localparam logic [1:0] CMD_GAUGE = 2'd0;
    localparam logic [1:0] CMD_SLEEP = 2'd1;
    localparam logic [1:0] CMD_FAULT = 2'd2;

    // Colors, packed red<<16 | green<<8 | blue
    localparam logic [COLOR_W-1:0] COL_OFF    = 24'h000000;
    localparam logic [COLOR_W-1:0] COL_GREEN  = 24'h004000;
    localparam logic [COLOR_W-1:0] COL_YELLOW = 24'h6E1E00;
    localparam logic [COLOR_W-1:0] COL_RED    = 24'h400000;
    localparam logic [COLOR_W-1:0] COL_SLEEP  = 24'h001400;

    // Charge band thresholds (percent)
    localparam logic [PCT_W-1:0] PCT_FULL = 8'd75;
    localparam logic [PCT_W-1:0] PCT_HIGH = 8'd50;
    localparam logic [PCT_W-1:0] PCT_MID  = 8'd25;
    localparam logic [PCT_W-1:0] PCT_LOW  = 8'd20;
    localparam logic [PCT_W-1:0] PCT_CRIT = 8'd10;

    typedef logic [PIXEL_COUNT-1:0][COLOR_W-1:0] t_pixels;

    // What an accepted item turns into
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_STATIC,
        KIND_FADE
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic mul_step;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_kind kind;
    } t_dp_stat;

    // Datapath to each scaling lane
    typedef struct packed {
        logic load;
        logic mul_step;
        logic div_step;
    } t_lane_cmd;

    // Gauge pattern for a charge level
    function automatic t_pixels band_colors(input logic [PCT_W-1:0] pct);
        t_pixels c;
        c = '{default: COL_OFF};
        if (pct > PCT_FULL) begin
            c = '{default: COL_GREEN};
        end else if (pct > PCT_HIGH) begin
            c[1] = COL_GREEN;
            c[2] = COL_GREEN;
            c[3] = COL_GREEN;
        end else if (pct > PCT_MID) begin
            c[2] = COL_GREEN;
            c[3] = COL_GREEN;
        end else if (pct > PCT_LOW) begin
            c[3] = COL_GREEN;
        end else if (pct > PCT_CRIT) begin
            c[3] = COL_YELLOW;
        end else begin
            c[3] = COL_RED;
        end
        return c;
    endfunction

endpackage

@@ sv/blbf_lane.sv @@
// One color channel scaler: floor(target * count / steps).
// Shift-add multiply then restoring divide, one bit per cycle. Uses blbf_pkg.
module blbf_lane import blbf_pkg::*; (
    input  logic              i_clk,
    input  t_lane_cmd         i_ctl,
    input  logic [CHAN_W-1:0] i_target,
    input  logic [FADE_W-1:0] i_count,
    input  logic [FADE_W-1:0] i_steps,
    output logic [CHAN_W-1:0] o_quot
);

    logic [CHAN_W-1:0] r_mcand;
    logic [PROD_W-1:0] r_acc;
    logic [PROD_W-1:0] mul_sum;
    logic [FADE_W:0]   rem_ext;
    logic [FADE_W:0]   rem_new;
    logic              rem_ge;
    logic [PROD_W-1:0] div_next;

    // Multiply step, multiplicand MSB first
    assign mul_sum = {r_acc[PROD_W-2:0], 1'b0}
                   + (r_mcand[CHAN_W-1] ? {{CHAN_W{1'b0}}, i_count} : {PROD_W{1'b0}});

    // Divide step: upper bits hold the remainder, low bits collect the quotient
    assign rem_ext  = {r_acc[PROD_W-1:CHAN_W], r_acc[CHAN_W-1]};
    assign rem_ge   = rem_ext >= {1'b0, i_steps};
    assign rem_new  = rem_ge ? (rem_ext - {1'b0, i_steps}) : rem_ext;
    assign div_next = {rem_new[FADE_W-1:0], r_acc[CHAN_W-2:0], rem_ge};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mcand <= i_target;
            r_acc   <= '0;
        end else if (i_ctl.mul_step) begin
            r_mcand <= {r_mcand[CHAN_W-2:0], 1'b0};
            r_acc   <= mul_sum;
        end else if (i_ctl.div_step) begin
            r_acc   <= div_next;
        end
    end

    assign o_quot = r_acc[CHAN_W-1:0];

endmodule

@@ sv/blbf_ctrl.sv @@
// Sequencer for the light bar fader: accept, multiply, divide, hand off result.
// Drives the datapath through t_dp_cmd. Uses blbf_pkg.
module blbf_ctrl import blbf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    output logic     o_valid,
    input  logic     i_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              accept;
    logic              out_load;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_stall);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_stat.kind)
                        KIND_STATIC: n_state = S_OUT;
                        KIND_FADE:   n_state = S_MUL;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_MUL: begin
                if (r_step == STEP_LAST) n_state = S_DIV;
            end
            S_DIV: begin
                if (r_step == STEP_LAST) n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Bit counter for the multiply and divide phases; wraps into the next phase
    always_comb begin
        if (r_state == S_MUL || r_state == S_DIV) begin
            n_step = r_step + 1'b1;
        end else begin
            n_step = '0;
        end
    end

    // Output item register valid
    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Commands
    always_comb begin
        o_cmd.load     = accept;
        o_cmd.mul_step = (r_state == S_MUL);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.out_load = out_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    a_fade_starts_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_stat.kind == KIND_FADE) |=> (r_state == S_MUL))
        else $error("fade item did not start the multiply phase");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_step == STEP_LAST) |=> (r_state == S_OUT))
        else $error("divide phase overran");

    a_valid_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result raised outside the output state");

endmodule

@@ sv/blbf_datapath.sv @@
// Datapath: item decode, fader state, latched targets, twelve channel lanes
// and the output item register. Uses blbf_pkg and blbf_lane.
module blbf_datapath import blbf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_ctl,
    output t_dp_stat             o_stat,
    input  logic                 i_bar_enabled,
    input  logic [FADE_W-1:0]    i_fade_steps,
    input  logic [1:0]           i_cmd,
    input  logic [PCT_W-1:0]     i_charge_pct,
    input  logic                 i_stop_engaged,
    input  logic                 i_stop_led_lit,
    input  logic                 i_charger_present,
    output t_pixels              o_pixels
);

    t_kind             kind;
    t_pixels           band;
    t_pixels           static_pix;
    t_pixels           item_tgt;
    t_pixels           tgt_next;
    t_pixels           fade_pix;
    logic [FADE_W-1:0] steps_eff;
    logic [FADE_W-1:0] base_count;
    logic              base_rising;
    logic [FADE_W:0]   cnt_step;
    logic [FADE_W-1:0] cnt_next;
    logic              rising_next;
    t_lane_cmd         lane_ctl;

    logic [FADE_W-1:0] r_fade_count;
    logic              r_fade_rising;
    logic              r_fade_latched;
    t_pixels           r_target;
    t_pixels           r_static;
    logic              r_use_fade;
    logic              r_mask;
    t_pixels           r_pix;

    // Item decode
    always_comb begin
        band       = band_colors(i_charge_pct);
        static_pix = '{default: COL_OFF};
        item_tgt   = band;
        kind       = KIND_NONE;
        if (i_bar_enabled) begin
            unique case (i_cmd)
                CMD_FAULT: begin
                    kind          = KIND_STATIC;
                    static_pix[3] = COL_RED;
                end
                CMD_SLEEP: begin
                    kind     = KIND_FADE;
                    item_tgt = '{default: COL_SLEEP};
                end
                CMD_GAUGE: begin
                    if (i_stop_engaged && !i_stop_led_lit) begin
                        kind = KIND_STATIC;
                    end else if (!i_charger_present || i_stop_engaged) begin
                        kind       = KIND_STATIC;
                        static_pix = band;
                    end else begin
                        kind = KIND_FADE;
                    end
                end
                default: kind = KIND_NONE;
            endcase
        end
    end

    assign o_stat.kind = kind;

    // Fader step; targets are taken only when the counter is unlatched
    assign steps_eff   = (i_fade_steps == '0) ? FADE_W'(1) : i_fade_steps;
    assign base_count  = r_fade_latched ? r_fade_count : '0;
    assign base_rising = r_fade_latched ? r_fade_rising : 1'b1;
    assign tgt_next    = r_fade_latched ? r_target : item_tgt;

    always_comb begin
        if (base_rising) begin
            cnt_step = {1'b0, base_count} + 1'b1;
        end else if (base_count != '0) begin
            cnt_step = {1'b0, base_count} - 1'b1;
        end else begin
            cnt_step = '0;
        end
        if (cnt_step > {1'b0, steps_eff}) begin
            cnt_next = steps_eff;
        end else begin
            cnt_next = cnt_step[FADE_W-1:0];
        end
        priority if (cnt_next == '0 && !base_rising) begin
            rising_next = 1'b1;
        end else if (cnt_next == steps_eff && base_rising) begin
            rising_next = 1'b0;
        end else begin
            rising_next = base_rising;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_count   <= '0;
            r_fade_rising  <= 1'b1;
            r_fade_latched <= 1'b0;
            r_target       <= '{default: COL_OFF};
        end else if (i_ctl.load && kind == KIND_FADE) begin
            r_fade_count   <= cnt_next;
            r_fade_rising  <= rising_next;
            r_fade_latched <= (cnt_next != '0);
            r_target       <= tgt_next;
        end
    end

    // Per-item flags and static colors
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_static   <= static_pix;
            r_use_fade <= (kind == KIND_FADE);
            r_mask     <= (i_cmd == CMD_GAUGE) && (i_charge_pct <= PCT_MID);
        end
    end

    // Channel lanes, one per pixel and color
    assign lane_ctl.load     = i_ctl.load;
    assign lane_ctl.mul_step = i_ctl.mul_step;
    assign lane_ctl.div_step = i_ctl.div_step;

    for (genvar p = 0; p < PIXEL_COUNT; p++) begin : g_pix
        for (genvar c = 0; c < CHAN_COUNT; c++) begin : g_chan
            blbf_lane u_lane (
                .i_clk    (i_clk),
                .i_ctl    (lane_ctl),
                .i_target (tgt_next[p][c*CHAN_W +: CHAN_W]),
                .i_count  (r_fade_count),
                .i_steps  (steps_eff),
                .o_quot   (fade_pix[p][c*CHAN_W +: CHAN_W])
            );
        end
    end

    // Output item register; low-charge gauge keeps only pixel 3
    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            for (int p = 0; p < PIXEL_COUNT; p++) begin
                if (!r_use_fade) begin
                    r_pix[p] <= r_static[p];
                end else if (r_mask && p != PIXEL_COUNT - 1) begin
                    r_pix[p] <= COL_OFF;
                end else begin
                    r_pix[p] <= fade_pix[p];
                end
            end
        end
    end

    assign o_pixels = r_pix;

    a_latch_tracks_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fade_latched == (r_fade_count != '0))
        else $error("fade latch disagrees with counter");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.load && kind == KIND_FADE) |=> (r_fade_count <= steps_eff))
        else $error("fade counter above step count");

    a_low_charge_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.out_load && r_use_fade && r_mask) |=>
        (r_pix[0] == COL_OFF && r_pix[1] == COL_OFF && r_pix[2] == COL_OFF))
        else $error("low-charge gauge lit a masked pixel");

endmodule

@@ sv/battery_light_bar_fader_unit.sv @@
// Top level of the battery light bar fader: configuration registers and the
// controller/datapath pair. Uses blbf_pkg, blbf_ctrl, blbf_datapath.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one tick item: cmd, charge_pct,
//   stop_engaged, stop_led_lit, charger_present. Output channel (o_valid /
//   i_stall) carries one item of four packed 0xRRGGBB pixel colors.
//   An item is taken only while the sequencer is idle, so one item is in work
//   at a time. A tick with the bar disabled or an unused command gives no
//   result. Static displays (fault, blanked, plain gauge) skip the multiply
//   and divide phases and go from acceptance through the output state into
//   the output register. Breathing ticks run a shift-add multiply phase and
//   then a restoring divide phase in twelve channel lanes, and the block
//   takes no new item until the breathing result has left the output state.
//   The output register frees the input side: a waiting result does not block
//   the next accept; only a second result waits in the output state while
//   i_stall is high. Synchronous reset clears the fader (count 0, rising,
//   unlatched), the targets, bar_enabled and sets fade_steps to 1000.
//   Registers: bar_enabled at byte 0x0, fade_steps at byte 0x4; the user must
//   write them only while no item is in work; the block does not enforce it.
module battery_light_bar_fader_unit import blbf_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    // input items
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [1:0]             i_cmd,
    input  logic [PCT_W-1:0]       i_charge_pct,
    input  logic                   i_stop_engaged,
    input  logic                   i_stop_led_lit,
    input  logic                   i_charger_present,
    // result items
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [COLOR_W-1:0]     o_pixel_zero,
    output logic [COLOR_W-1:0]     o_pixel_one,
    output logic [COLOR_W-1:0]     o_pixel_two,
    output logic [COLOR_W-1:0]     o_pixel_three
);

    logic              r_bar_enabled;
    logic [FADE_W-1:0] r_fade_steps;
    logic              cfg_wr;
    logic              reg_sel;
    t_dp_cmd           dp_cmd;
    t_dp_stat          dp_stat;
    t_pixels           pixels;

    // Register file
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bar_enabled <= 1'b0;
            r_fade_steps  <= FADE_STEPS_RST;
        end else if (cfg_wr) begin
            if (reg_sel == REG_BAR_ENABLED) begin
                r_bar_enabled <= pwdata[0];
            end else begin
                r_fade_steps  <= pwdata[FADE_W-1:0];
            end
        end
    end

    always_comb begin
        if (reg_sel == REG_FADE_STEPS) begin
            prdata = {{(APB_DATA_W-FADE_W){1'b0}}, r_fade_steps};
        end else begin
            prdata = {{(APB_DATA_W-1){1'b0}}, r_bar_enabled};
        end
    end

    blbf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    blbf_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (dp_cmd),
        .o_stat            (dp_stat),
        .i_bar_enabled     (r_bar_enabled),
        .i_fade_steps      (r_fade_steps),
        .i_cmd             (i_cmd),
        .i_charge_pct      (i_charge_pct),
        .i_stop_engaged    (i_stop_engaged),
        .i_stop_led_lit    (i_stop_led_lit),
        .i_charger_present (i_charger_present),
        .o_pixels          (pixels)
    );

    assign o_pixel_zero  = pixels[0];
    assign o_pixel_one   = pixels[1];
    assign o_pixel_two   = pixels[2];
    assign o_pixel_three = pixels[3];

endmodule
